// ----- rtl/dateadd_pkg.sv -----
// Shared types, constants and calendar helpers for the signed date adder.
package dateadd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned R400_W  = 9;

  localparam logic [MONTH_W-1:0] MonthJan = 4'd1;
  localparam logic [MONTH_W-1:0] MonthFeb = 4'd2;
  localparam logic [MONTH_W-1:0] MonthApr = 4'd4;
  localparam logic [MONTH_W-1:0] MonthJun = 4'd6;
  localparam logic [MONTH_W-1:0] MonthSep = 4'd9;
  localparam logic [MONTH_W-1:0] MonthNov = 4'd11;
  localparam logic [MONTH_W-1:0] MonthDec = 4'd12;

  localparam logic [YEAR_W-1:0] YearMin      = 14'd1;
  localparam logic [YEAR_W-1:0] YearMax      = 14'd9999;
  localparam logic [YEAR_W-1:0] GregResetVal = 14'd1582;

  localparam logic [R400_W-1:0] CycleLast = 9'd399;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } dateadd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fin;
  } dateadd_stat_t;

  // Year modulo 400 by restoring subtraction of 400 times a power of two.
  function automatic logic [R400_W-1:0] year_mod400(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] t;
    t = y;
    if (t >= 14'd6400) t = t - 14'd6400;
    if (t >= 14'd3200) t = t - 14'd3200;
    if (t >= 14'd1600) t = t - 14'd1600;
    if (t >= 14'd800)  t = t - 14'd800;
    if (t >= 14'd400)  t = t - 14'd400;
    return t[R400_W-1:0];
  endfunction

  // Leap test given the year, its residue modulo 400 and the switch year.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                   input logic [R400_W-1:0] r400,
                                   input logic [YEAR_W-1:0] greg);
    logic [R400_W-1:0] r100;
    logic              lp;
    r100 = r400;
    if (r100 >= 9'd200) r100 = r100 - 9'd200;
    if (r100 >= 9'd100) r100 = r100 - 9'd100;
    if (y > greg) begin
      lp = (r400 == '0) || ((r100 != '0) && (y[1:0] == 2'b00));
    end else begin
      lp = (y[1:0] == 2'b00);
    end
    return lp;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m == MonthFeb) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// ----- rtl/date_add_signed_days_core.sv -----
// Top level of the signed day offset date adder.
//
// A request is taken at a rising edge where start is high and busy is low. It
// carries a start date and a signed day offset of OFFSET_BITS bits. The block
// then walks the calendar one month per clock cycle, forward or backward, and
// wraps the year at December and January. Years above the configured switch
// year use the Gregorian leap rule, the others the Julian rule.
// The result appears for exactly one cycle with result_valid_o high, in the cycle
// after the walk ends. The length of the walk is set by the number of month
// boundaries crossed (about 2200 for an offset of 65536 days). busy stays high
// until the strobe cycle, so only one request is in flight.
// A result year outside 1..9999, or a start year outside it, raises range_error_o
// and echoes the start date. The receiver cannot stall. The user writes the switch
// year with gregorian_after_year_we_i only while idle; the block does not enforce it.
// Reset aborts any walk, drops the strobe and sets the switch year to 1582.
module date_add_signed_days_core #(
  parameter int unsigned OFFSET_BITS = 17
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [dateadd_pkg::DAY_W-1:0]    start_day_i,
  input  logic [dateadd_pkg::MONTH_W-1:0]  start_month_i,
  input  logic [dateadd_pkg::YEAR_W-1:0]   start_year_i,
  input  logic signed [OFFSET_BITS-1:0]    day_offset_i,
  input  logic                             gregorian_after_year_we_i,
  input  logic [dateadd_pkg::YEAR_W-1:0]   gregorian_after_year_i,
  output logic                             result_valid_o,
  output logic [dateadd_pkg::DAY_W-1:0]    result_day_o,
  output logic [dateadd_pkg::MONTH_W-1:0]  result_month_o,
  output logic [dateadd_pkg::YEAR_W-1:0]   result_year_o,
  output logic                             range_error_o
);
  import dateadd_pkg::*;

  dateadd_cmd_t  cmd;
  dateadd_stat_t stat;

  dateadd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .valid_o (result_valid_o)
  );

  dateadd_dp #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (gregorian_after_year_we_i),
    .cfg_wdata_i    (gregorian_after_year_i),
    .start_day_i    (start_day_i),
    .start_month_i  (start_month_i),
    .start_year_i   (start_year_i),
    .day_offset_i   (day_offset_i),
    .result_day_o   (result_day_o),
    .result_month_o (result_month_o),
    .result_year_o  (result_year_o),
    .range_error_o  (range_error_o)
  );

  // The strobe comes in the cycle after the walk ends, when the block is idle again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("accepted request did not start a walk");

  // A result without error is always a real calendar date.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !range_error_o) |->
      (result_month_o >= MonthJan && result_month_o <= MonthDec &&
       result_day_o != '0 && result_year_o >= YearMin && result_year_o <= YearMax))
    else $error("result date out of range without range error");

endmodule

// ----- rtl/dateadd_ctrl.sv -----
// Controller state machine: accepts a request, runs the month walk, strobes the result.
module dateadd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  dateadd_pkg::dateadd_stat_t stat_i,
  output dateadd_pkg::dateadd_cmd_t  cmd_o,
  output logic                   busy_o,
  output logic                   valid_o
);
  import dateadd_pkg::*;

  typedef enum logic {
    StIdle,
    StWalk
  } state_e;

  state_e state_q;
  logic   valid_q;

  always_comb begin
    cmd_o.load    = (state_q == StIdle) && start_i;
    cmd_o.step    = (state_q == StWalk);
    cmd_o.capture = (state_q == StWalk) && stat_i.fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) state_q <= StWalk;
        end
        StWalk: begin
          if (stat_i.fin) begin
            state_q <= StIdle;
            valid_q <= 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o  = (state_q == StWalk);
  assign valid_o = valid_q;

endmodule

// ----- rtl/dateadd_dp.sv -----
// Datapath: day count, month, year and year residue registers with one month step per cycle.
module dateadd_dp #(
  parameter int unsigned OFFSET_BITS = 17
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dateadd_pkg::dateadd_cmd_t        cmd_i,
  output dateadd_pkg::dateadd_stat_t       stat_o,
  input  logic                             cfg_we_i,
  input  logic [dateadd_pkg::YEAR_W-1:0]   cfg_wdata_i,
  input  logic [dateadd_pkg::DAY_W-1:0]    start_day_i,
  input  logic [dateadd_pkg::MONTH_W-1:0]  start_month_i,
  input  logic [dateadd_pkg::YEAR_W-1:0]   start_year_i,
  input  logic signed [OFFSET_BITS-1:0]    day_offset_i,
  output logic [dateadd_pkg::DAY_W-1:0]    result_day_o,
  output logic [dateadd_pkg::MONTH_W-1:0]  result_month_o,
  output logic [dateadd_pkg::YEAR_W-1:0]   result_year_o,
  output logic                             range_error_o
);
  import dateadd_pkg::*;

  localparam int unsigned NW = OFFSET_BITS + 1;

  logic [YEAR_W-1:0]      greg_q;
  logic signed [NW-1:0]   n_q, n_d, n_load;
  logic [MONTH_W-1:0]     m_q, m_d, m_load;
  logic [YEAR_W-1:0]      y_q, y_d;
  logic [R400_W-1:0]      r_q, r_d;
  logic                   bad_q;
  logic [DAY_W-1:0]       d_raw_q;
  logic [MONTH_W-1:0]     m_raw_q;
  logic [YEAR_W-1:0]      y_raw_q;
  logic [DAY_W-1:0]       res_day_q;
  logic [MONTH_W-1:0]     res_month_q;
  logic [YEAR_W-1:0]      res_year_q;
  logic                   res_err_q;

  logic [DAY_W-1:0]       len_cur, len_prev;
  logic [MONTH_W-1:0]     m_prev, m_next;
  logic [YEAR_W-1:0]      y_prev, y_next;
  logic [R400_W-1:0]      r_prev, r_next;
  logic                   fwd, bwd, ovf, unf, err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      greg_q <= GregResetVal;
    end else if (cfg_we_i) begin
      greg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    n_load = $signed({{(NW-DAY_W){1'b0}}, start_day_i}) +
             $signed({day_offset_i[OFFSET_BITS-1], day_offset_i});
    if (start_month_i < MonthJan) begin
      m_load = MonthJan;
    end else if (start_month_i > MonthDec) begin
      m_load = MonthDec;
    end else begin
      m_load = start_month_i;
    end
  end

  // Neighbor months; the residue modulo 400 follows the year across a wrap.
  always_comb begin
    if (m_q == MonthDec) begin
      m_next = MonthJan;
      y_next = y_q + 14'd1;
      r_next = (r_q == CycleLast) ? '0 : r_q + 9'd1;
    end else begin
      m_next = m_q + 4'd1;
      y_next = y_q;
      r_next = r_q;
    end
    if (m_q == MonthJan) begin
      m_prev = MonthDec;
      y_prev = y_q - 14'd1;
      r_prev = (r_q == '0) ? CycleLast : r_q - 9'd1;
    end else begin
      m_prev = m_q - 4'd1;
      y_prev = y_q;
      r_prev = r_q;
    end
    len_cur  = month_len(m_q, is_leap(y_q, r_q, greg_q));
    len_prev = month_len(m_prev, is_leap(y_prev, r_prev, greg_q));
    fwd = n_q > $signed({{(NW-DAY_W){1'b0}}, len_cur});
    bwd = n_q < $signed({{(NW-1){1'b0}}, 1'b1});
    // The year moves one way only, so leaving the range ends the walk at once.
    ovf = fwd && (m_q == MonthDec) && (y_q == YearMax);
    unf = bwd && (m_q == MonthJan) && (y_q == YearMin);
    err = bad_q || ovf || unf;
    stat_o.fin = err || (!fwd && !bwd);
  end

  always_comb begin
    n_d = n_q;
    m_d = m_q;
    y_d = y_q;
    r_d = r_q;
    if (fwd) begin
      n_d = n_q - $signed({{(NW-DAY_W){1'b0}}, len_cur});
      m_d = m_next;
      y_d = y_next;
      r_d = r_next;
    end else if (bwd) begin
      n_d = n_q + $signed({{(NW-DAY_W){1'b0}}, len_prev});
      m_d = m_prev;
      y_d = y_prev;
      r_d = r_prev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= 1'b0;
    end else if (cmd_i.load) begin
      bad_q <= (start_year_i < YearMin) || (start_year_i > YearMax);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q     <= n_load;
      m_q     <= m_load;
      y_q     <= start_year_i;
      r_q     <= year_mod400(start_year_i);
      d_raw_q <= start_day_i;
      m_raw_q <= start_month_i;
      y_raw_q <= start_year_i;
    end else if (cmd_i.step && !stat_o.fin) begin
      n_q <= n_d;
      m_q <= m_d;
      y_q <= y_d;
      r_q <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_err_q <= err;
      if (err) begin
        res_day_q   <= d_raw_q;
        res_month_q <= m_raw_q;
        res_year_q  <= y_raw_q;
      end else begin
        res_day_q   <= n_q[DAY_W-1:0];
        res_month_q <= m_q;
        res_year_q  <= y_q;
      end
    end
  end

  assign result_day_o   = res_day_q;
  assign result_month_o = res_month_q;
  assign result_year_o  = res_year_q;
  assign range_error_o  = res_err_q;

endmodule
